// ----- hdl/u64_to_decimal_ascii_macros.svh -----
// Assertion macros for the decimal text converter.
// Each macro uses the clk and rst names of the module that includes it.
`ifndef U64_TO_DECIMAL_ASCII_MACROS_SVH
`define U64_TO_DECIMAL_ASCII_MACROS_SVH

`ifndef ASSERT_OFF

`define U64DA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("u64da: same-cycle check failed");

`define U64DA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("u64da: next-cycle check failed");

`else

`define U64DA_ASSERT_IMP(label, ante, cons)

`define U64DA_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ----- hdl/u64da_pkg.sv -----
package u64da_pkg;

  localparam int BIN_W  = 64;
  localparam int DIGITS = 20;
  localparam int BCD_W  = 4 * DIGITS;
  localparam int STEP_W = $clog2(BIN_W);
  localparam int CNT_W  = $clog2(DIGITS + 1);
  localparam int CHAR_W = 6;

  // ASCII '0' is 6'b110000; a digit below 16 sits in the low nibble
  localparam logic [1:0] ASCII_ZERO_HI = 2'b11;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_RUN,
    CORE_DONE
  } core_state_t;

  typedef enum logic [1:0] {
    EMIT_IDLE,
    EMIT_SKIP,
    EMIT_SEND
  } emit_state_t;

  typedef struct packed {
    logic idle;
    logic done;
  } core_status_t;

  function automatic logic [3:0] add3(input logic [3:0] d);
    logic [3:0] r;
    r = (d >= 4'd5) ? d + 4'd3 : d;
    return r;
  endfunction

endpackage

// ----- hdl/u64da_if.sv -----
interface u64da_num_if;
  logic                          valid;
  logic                          ready;
  logic [u64da_pkg::BIN_W-1:0]   value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface u64da_text_if;
  logic                          valid;
  logic                          ready;
  logic [u64da_pkg::CHAR_W-1:0]  digit_char;
  logic                          last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

// ----- hdl/u64_to_decimal_ascii.sv -----
// Converts an unsigned 64-bit value to decimal ASCII digits, most significant
// first, no leading zeros (zero gives a single '0'); last_digit marks the final
// digit. A value is converted by a shift-add-3 loop, one bit per cycle; the
// digits are then handed to an output shift register that drops leading zeros
// one per cycle and sends one digit per transfer. The next value is accepted
// as soon as the converter hands off its result, so its conversion overlaps
// the previous value's output.
`include "u64_to_decimal_ascii_macros.svh"

module u64_to_decimal_ascii (
  input  logic         clk,
  input  logic         rst,
  u64da_num_if.sink    num,
  u64da_text_if.source text
);
  import u64da_pkg::*;

  core_status_t       core_st;
  logic [BCD_W-1:0]   core_bcd;
  logic               start, take;

  emit_state_t        state, state_next;
  logic [BCD_W-1:0]   dig, dig_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [3:0]         top;
  logic               last;

  assign num.ready = core_st.idle;
  assign start     = num.valid && num.ready;
  assign take      = core_st.done && (state == EMIT_IDLE);

  u64da_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .value (num.value),
    .take  (take),
    .st    (core_st),
    .bcd   (core_bcd)
  );

  assign top  = dig[BCD_W-1 -: 4];
  assign last = (cnt == CNT_W'(1));

  always_comb begin
    state_next = state;
    dig_next   = dig;
    cnt_next   = cnt;
    text.valid = 1'b0;
    case (state)
      EMIT_IDLE: begin
        if (take) begin
          dig_next   = core_bcd;
          cnt_next   = CNT_W'(DIGITS);
          state_next = EMIT_SKIP;
        end
      end
      EMIT_SKIP: begin
        if (top == 4'd0 && !last) begin
          dig_next = {dig[BCD_W-5:0], 4'd0};
          cnt_next = cnt - 1'b1;
        end else begin
          state_next = EMIT_SEND;
        end
      end
      EMIT_SEND: begin
        text.valid = 1'b1;
        if (text.ready) begin
          if (last) begin
            state_next = EMIT_IDLE;
          end else begin
            dig_next = {dig[BCD_W-5:0], 4'd0};
            cnt_next = cnt - 1'b1;
          end
        end
      end
      default: begin
        state_next = EMIT_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= EMIT_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    dig <= dig_next;
    cnt <= cnt_next;
  end

  assign text.digit_char = {ASCII_ZERO_HI, top};
  assign text.last_digit = last;

  `U64DA_ASSERT_IMP(a_digit_range, text.valid, (text.digit_char >= 6'd48 && text.digit_char <= 6'd57))
  `U64DA_ASSERT_NXT(a_no_gap, text.valid && text.ready && !text.last_digit, text.valid)
  `U64DA_ASSERT_NXT(a_busy_after_accept, num.valid && num.ready, !num.ready)
  `U64DA_ASSERT_NXT(a_result_held, core_st.done && !take, core_st.done)

endmodule

// ----- hdl/u64da_dabble.sv -----
module u64da_dabble (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [u64da_pkg::BIN_W-1:0]   value,
  input  logic                          take,
  output u64da_pkg::core_status_t       st,
  output logic [u64da_pkg::BCD_W-1:0]   bcd
);
  import u64da_pkg::*;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(BIN_W - 1);

  core_state_t       state, state_next;
  logic [BIN_W-1:0]  bin, bin_next;
  logic [BCD_W-1:0]  bcd_next, adj;
  logic [STEP_W-1:0] step, step_next;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      adj[4*i +: 4] = add3(bcd[4*i +: 4]);
    end
  end

  always_comb begin
    state_next = state;
    bin_next   = bin;
    bcd_next   = bcd;
    step_next  = step;
    case (state)
      CORE_IDLE: begin
        if (start) begin
          bin_next   = value;
          bcd_next   = '0;
          step_next  = '0;
          state_next = CORE_RUN;
        end
      end
      CORE_RUN: begin
        bcd_next  = {adj[BCD_W-2:0], bin[BIN_W-1]};
        bin_next  = {bin[BIN_W-2:0], 1'b0};
        step_next = step + 1'b1;
        if (step == STEP_LAST) begin
          state_next = CORE_DONE;
        end
      end
      CORE_DONE: begin
        if (take) begin
          state_next = CORE_IDLE;
        end
      end
      default: begin
        state_next = CORE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CORE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    bin  <= bin_next;
    bcd  <= bcd_next;
    step <= step_next;
  end

  assign st.idle = (state == CORE_IDLE);
  assign st.done = (state == CORE_DONE);

endmodule

// ----- dv/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import u64da_pkg::*;

  localparam logic [BIN_W-1:0]  DEC_BASE   = 64'd10;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 210;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;
  } digit_t;

  class decimal_text_board;
    digit_t digits_due[$];
    int     errors = 0;

    task report(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    function int pending();
      return digits_due.size();
    endfunction

    // least significant digit first, then queued most significant first
    function void note_value(input logic [BIN_W-1:0] value);
      logic [3:0]       rev[DIGITS];
      logic [BIN_W-1:0] v;
      int               n;
      digit_t           d;
      v = value;
      n = 0;
      do begin
        rev[n] = 4'(v % DEC_BASE);
        n++;
        v = v / DEC_BASE;
      end while (v != '0 && n < DIGITS);
      for (int k = 0; k < n; k++) begin
        d.digit_char = ASCII_ZERO + CHAR_W'(rev[n - 1 - k]);
        d.last_digit = (k == n - 1);
        digits_due.push_back(d);
      end
    endfunction

    task check_digit(input logic [CHAR_W-1:0] digit_char, input logic last_digit);
      digit_t want;
      if (digits_due.size() == 0) begin
        report($sformatf("unexpected digit_char %0d last_digit %0b", digit_char, last_digit));
      end else begin
        want = digits_due.pop_front();
        if (digit_char !== want.digit_char)
          report($sformatf("digit_char got %0d want %0d", digit_char, want.digit_char));
        if (last_digit !== want.last_digit)
          report($sformatf("last_digit got %0b want %0b", last_digit, want.last_digit));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic src_idle_en  = 1'b1;
  logic sink_idle_en = 1'b1;
  logic hold_req     = 1'b0;
  int   stall_count  = 0;

  decimal_text_board board = new();

  u64da_num_if  num();
  u64da_text_if text();

  u64_to_decimal_ascii uut (
    .clk  (clk),
    .rst  (rst),
    .num  (num.sink),
    .text (text.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && num.valid && num.ready)
      board.note_value(num.value);
    if (!rst && text.valid && text.ready)
      board.check_digit(text.digit_char, text.last_digit);
  end

  always @(posedge clk) begin
    if (rst || (num.valid && num.ready) || (text.valid && text.ready)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    int burst;
    burst = 0;
    text.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        text.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (burst > 0) begin
        text.ready = 1'b0;
        burst--;
      end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
        text.ready = 1'b0;
        burst = $urandom_range(0, 9);
      end else begin
        text.ready = 1'b1;
      end
    end
  end

  function automatic logic [BIN_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int source_gap();
    if (src_idle_en && $urandom_range(0, 3) == 0)
      return $urandom_range(1, 10);
    return 0;
  endfunction

  // called and returns at a falling edge
  task send_value(input logic [BIN_W-1:0] value, input int gap);
    if (gap > 0) begin
      num.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    num.valid = 1'b1;
    num.value = value;
    do @(posedge clk); while (!num.ready);
    @(negedge clk);
    num.valid = 1'b0;
  endtask

  function automatic logic [BIN_W-1:0] random_value();
    logic [BIN_W-1:0] scale;
    int               n;
    case ($urandom_range(0, 4))
      0: return rand64();
      1: return BIN_W'($urandom_range(0, 20));
      2: return 64'd1 << $urandom_range(0, BIN_W - 1);
      default: begin
        n = $urandom_range(1, DIGITS - 1);
        scale = 64'd1;
        repeat (n) scale = scale * DEC_BASE;
        return rand64() % scale;
      end
    endcase
  endfunction

  task send_random(input int count);
    repeat (count) send_value(random_value(), source_gap());
  endtask

  task wait_drained();
    while (board.pending() != 0) @(negedge clk);
  endtask

  initial begin
    logic [BIN_W-1:0] directed[$];
    num.valid = 1'b0;
    num.value = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed = '{64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100, 64'd1234567890,
                 64'd9876543210, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
                 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                 64'd10000000000000000000, 64'd9999999999999999999,
                 64'd1000000000000000000, 64'd4294967295, 64'd4294967296,
                 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                 64'd10203040506070809, 64'd7};
    foreach (directed[i]) send_value(directed[i], source_gap());

    send_random(70);

    // long receiver hold while values keep coming: the input must back up
    hold_req = 1'b1;
    repeat (8) send_value(random_value(), 0);
    send_random(50);

    // let everything drain before offering more
    wait_drained();
    send_random(40);

    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    send_random(RANDOM_ITEMS - 189);

    wait_drained();
    repeat (100) @(posedge clk);
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
